// ----- design/quaternion_to_rotation_matrix_macros.svh -----
// Assertion macros used by the quaternion to rotation matrix checker.
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define QRM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define QRM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/qrm_pkg.sv -----
// Package with widths and payload types of the quaternion to rotation matrix block.
`timescale 1ns / 1ps
package qrm_pkg;
   localparam int IN_WIDTH = 16;
   localparam int OUT_WIDTH = 16;
   localparam int PROD_W = 2 * IN_WIDTH;
   localparam int N2_W = 2 * IN_WIDTH + 1;
   localparam int SUM_W = 2 * IN_WIDTH + 2;
   localparam int Q_W = 16;
   localparam int NUM_ENT = 9;
   localparam int DIV_STEPS = Q_W - 1;
   localparam logic [OUT_WIDTH-1:0] ONE_Q14 = OUT_WIDTH'(16384);

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] quat_w;
      logic signed [IN_WIDTH-1:0] quat_x;
      logic signed [IN_WIDTH-1:0] quat_y;
      logic signed [IN_WIDTH-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] rot_r0c0;
      logic signed [OUT_WIDTH-1:0] rot_r0c1;
      logic signed [OUT_WIDTH-1:0] rot_r0c2;
      logic signed [OUT_WIDTH-1:0] rot_r1c0;
      logic signed [OUT_WIDTH-1:0] rot_r1c1;
      logic signed [OUT_WIDTH-1:0] rot_r1c2;
      logic signed [OUT_WIDTH-1:0] rot_r2c0;
      logic signed [OUT_WIDTH-1:0] rot_r2c1;
      logic signed [OUT_WIDTH-1:0] rot_r2c2;
      logic                        degenerate;
   } rsp_type;

   // State of the nine parallel long divisions as it moves down the pipe.
   typedef struct packed {
      logic                              degen;
      logic [N2_W-1:0]                   n2;
      logic [NUM_ENT-1:0]                neg;
      logic [NUM_ENT-1:0][SUM_W-1:0]     rem;
      logic [NUM_ENT-1:0][Q_W-1:0]       quo;
   } div_type;
endpackage

// ----- design/qrm_front.sv -----
// Front pipeline: input register, products, matrix numerators and first quotient bit.
`timescale 1ns / 1ps
module qrm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  qrm_pkg::req_type         in_data,
   output logic                     out_valid,
   output qrm_pkg::div_type         out_div
);
   localparam int PW = qrm_pkg::PROD_W;
   localparam int SW = qrm_pkg::SUM_W;
   localparam int NE = qrm_pkg::NUM_ENT;

   logic                  a_valid_ff;
   qrm_pkg::req_type      a_data_ff;
   logic                  b_valid_ff;
   logic [3:0][PW-1:0]    b_sq_ff, b_sq_in;
   logic [5:0][PW-1:0]    b_cr_ff, b_cr_in;
   logic                  c_valid_ff;
   logic [qrm_pkg::N2_W-1:0] c_n2_ff, c_n2_in;
   logic [NE-1:0][SW-1:0] c_ent_ff, c_ent_in;
   logic                  d_valid_ff;
   qrm_pkg::div_type      d_div_ff, d_div_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_data_ff <= in_data;
         b_sq_ff   <= b_sq_in;
         b_cr_ff   <= b_cr_in;
         c_n2_ff   <= c_n2_in;
         c_ent_ff  <= c_ent_in;
         d_div_ff  <= d_div_in;
      end
   end

   // Squares in w, x, y, z order; cross products xy, xz, yz, wx, wy, wz.
   always_comb begin
      logic signed [PW-1:0] p0, p1, p2, p3, c0, c1, c2, c3, c4, c5;
      p0 = a_data_ff.quat_w * a_data_ff.quat_w;
      p1 = a_data_ff.quat_x * a_data_ff.quat_x;
      p2 = a_data_ff.quat_y * a_data_ff.quat_y;
      p3 = a_data_ff.quat_z * a_data_ff.quat_z;
      c0 = a_data_ff.quat_x * a_data_ff.quat_y;
      c1 = a_data_ff.quat_x * a_data_ff.quat_z;
      c2 = a_data_ff.quat_y * a_data_ff.quat_z;
      c3 = a_data_ff.quat_w * a_data_ff.quat_x;
      c4 = a_data_ff.quat_w * a_data_ff.quat_y;
      c5 = a_data_ff.quat_w * a_data_ff.quat_z;
      b_sq_in = {p3, p2, p1, p0};
      b_cr_in = {c5, c4, c3, c2, c1, c0};
   end

   // Numerators over n2: diagonal entries as signed sums of squares, the
   // others as twice a signed sum of cross products.
   always_comb begin
      logic signed [SW-1:0] sw, sx, sy, sz, xy, xz, yz, wx, wy, wz;
      sw = $signed({2'b00, b_sq_ff[0]});
      sx = $signed({2'b00, b_sq_ff[1]});
      sy = $signed({2'b00, b_sq_ff[2]});
      sz = $signed({2'b00, b_sq_ff[3]});
      xy = $signed({{2{b_cr_ff[0][PW-1]}}, b_cr_ff[0]});
      xz = $signed({{2{b_cr_ff[1][PW-1]}}, b_cr_ff[1]});
      yz = $signed({{2{b_cr_ff[2][PW-1]}}, b_cr_ff[2]});
      wx = $signed({{2{b_cr_ff[3][PW-1]}}, b_cr_ff[3]});
      wy = $signed({{2{b_cr_ff[4][PW-1]}}, b_cr_ff[4]});
      wz = $signed({{2{b_cr_ff[5][PW-1]}}, b_cr_ff[5]});
      c_n2_in = qrm_pkg::N2_W'(sw + sx + sy + sz);
      c_ent_in[0] = sw + sx - sy - sz;
      c_ent_in[1] = (xy - wz) <<< 1;
      c_ent_in[2] = (xz + wy) <<< 1;
      c_ent_in[3] = (xy + wz) <<< 1;
      c_ent_in[4] = sw - sx + sy - sz;
      c_ent_in[5] = (yz - wx) <<< 1;
      c_ent_in[6] = (xz - wy) <<< 1;
      c_ent_in[7] = (yz + wx) <<< 1;
      c_ent_in[8] = sw - sx - sy + sz;
   end

   // Magnitudes never exceed n2, so the leading quotient bit is set only
   // when the magnitude equals n2.
   always_comb begin
      logic [SW-1:0] mag;
      d_div_in.degen = (c_n2_ff == '0);
      d_div_in.n2 = c_n2_ff;
      for (int i = 0; i < NE; i++) begin
         d_div_in.neg[i] = c_ent_ff[i][SW-1];
         mag = c_ent_ff[i][SW-1] ? (SW)'(-c_ent_ff[i]) : c_ent_ff[i];
         if (mag == {1'b0, c_n2_ff}) begin
            d_div_in.rem[i] = '0;
            d_div_in.quo[i] = qrm_pkg::Q_W'(1);
         end else begin
            d_div_in.rem[i] = mag;
            d_div_in.quo[i] = '0;
         end
      end
   end

   assign out_valid = d_valid_ff;
   assign out_div   = d_div_ff;
endmodule

// ----- design/qrm_div_step.sv -----
// One restoring division step for all nine matrix entries, registered.
`timescale 1ns / 1ps
module qrm_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  qrm_pkg::div_type in_div,
   output logic             out_valid,
   output qrm_pkg::div_type out_div
);
   localparam int SW = qrm_pkg::SUM_W;

   logic             valid_ff;
   qrm_pkg::div_type div_ff, div_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   always_comb begin
      logic [SW-1:0] shifted;
      logic [SW-1:0] n2_ext;
      div_in = in_div;
      n2_ext = {1'b0, in_div.n2};
      for (int i = 0; i < qrm_pkg::NUM_ENT; i++) begin
         shifted = in_div.rem[i] << 1;
         if (shifted >= n2_ext) begin
            div_in.rem[i] = shifted - n2_ext;
            div_in.quo[i] = {in_div.quo[i][qrm_pkg::Q_W-2:0], 1'b1};
         end else begin
            div_in.rem[i] = shifted;
            div_in.quo[i] = {in_div.quo[i][qrm_pkg::Q_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
endmodule

// ----- design/qrm_out.sv -----
// Output stage: rounding, clamping, sign and the identity case, into the result register.
`timescale 1ns / 1ps
module qrm_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  qrm_pkg::div_type in_div,
   output logic             rsp_valid,
   output qrm_pkg::rsp_type rsp_data
);
   localparam int OW = qrm_pkg::OUT_WIDTH;
   localparam int QW = qrm_pkg::Q_W;

   logic             valid_ff;
   qrm_pkg::rsp_type data_ff, data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      logic [qrm_pkg::NUM_ENT-1:0][OW-1:0] ent;
      logic [QW:0]   rounded;
      logic [OW-1:0] mag;
      for (int i = 0; i < qrm_pkg::NUM_ENT; i++) begin
         // The quotient carries one extra fraction bit for round half away.
         rounded = ({1'b0, in_div.quo[i]} + (QW+1)'(1)) >> 1;
         if (rounded > (QW+1)'(qrm_pkg::ONE_Q14)) begin
            mag = qrm_pkg::ONE_Q14;
         end else begin
            mag = OW'(rounded);
         end
         ent[i] = in_div.neg[i] ? OW'(-mag) : mag;
      end
      if (in_div.degen) begin
         for (int i = 0; i < qrm_pkg::NUM_ENT; i++) begin
            ent[i] = (i % 4 == 0) ? qrm_pkg::ONE_Q14 : '0;
         end
      end
      data_in.rot_r0c0   = ent[0];
      data_in.rot_r0c1   = ent[1];
      data_in.rot_r0c2   = ent[2];
      data_in.rot_r1c0   = ent[3];
      data_in.rot_r1c1   = ent[4];
      data_in.rot_r1c2   = ent[5];
      data_in.rot_r2c0   = ent[6];
      data_in.rot_r2c1   = ent[7];
      data_in.rot_r2c2   = ent[8];
      data_in.degenerate = in_div.degen;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

// ----- design/quaternion_to_rotation_matrix.sv -----
// A request passes through 4 front stages, 15 division stages and 1 output register;
// throughput is one request per cycle while the result register is not stalled.
// The nine quotients come from a chain of one-bit restoring division stages.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
// Reset clears all valid bits synchronously; payload registers are not reset.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qrm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qrm_pkg::rsp_type rsp_data
);
   localparam int NS = qrm_pkg::DIV_STEPS;

   logic                   en;
   logic [NS:0]            stg_valid;
   qrm_pkg::div_type [NS:0] stg_div;

   // The pipe advances whenever the result register is free or being taken.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   qrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (stg_valid[0]),
      .out_div   (stg_div[0])
   );

   for (genvar g = 0; g < NS; g++) begin : g_div
      qrm_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stg_valid[g]),
         .in_div    (stg_div[g]),
         .out_valid (stg_valid[g+1]),
         .out_div   (stg_div[g+1])
      );
   end

   qrm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (stg_valid[NS]),
      .in_div    (stg_div[NS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

// ----- design/qrm_checker.sv -----
// Port checker for the quaternion to rotation matrix block and its bind.
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_macros.svh"
module qrm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input qrm_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input qrm_pkg::rsp_type rsp_data
);
   `QRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
   `QRM_ASSERT_NOW(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready, "request taken while pipe stalled")
   `QRM_ASSERT_NOW(a_identity, rsp_valid && rsp_data.degenerate, (rsp_data.rot_r0c0 == 16'sd16384) && (rsp_data.rot_r1c1 == 16'sd16384) && (rsp_data.rot_r2c2 == 16'sd16384) && (rsp_data.rot_r0c1 == 16'sd0) && (rsp_data.rot_r1c2 == 16'sd0) && (rsp_data.rot_r2c0 == 16'sd0), "degenerate result is not identity")
   `QRM_ASSERT_NOW(a_diag_range, rsp_valid, (rsp_data.rot_r0c0 >= -16'sd16384) && (rsp_data.rot_r0c0 <= 16'sd16384) && (rsp_data.rot_r1c1 >= -16'sd16384) && (rsp_data.rot_r1c1 <= 16'sd16384), "entry out of range")
   `QRM_ASSERT_NOW(a_idle_ready, !rsp_valid, req_ready, "request refused with empty result register")
endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (.*);
